FILE: sv/trial_division_factorizer_macros.svh
// Assertion macros shared by the checker of the trial-division factorizer.
// Each macro samples on clk and is disabled while rst is high.
`ifndef TRIAL_DIVISION_FACTORIZER_MACROS_SVH
`define TRIAL_DIVISION_FACTORIZER_MACROS_SVH

// Condition that must hold at every clock edge
`define TDF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tdf check failed");

// Antecedent implies the consequent on the following edge
`define TDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdf check failed");

`endif

FILE: sv/tdf_pkg.sv
// Package for the trial-division factorizer: sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package tdf_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,    // wait for an item
    ST_START,   // classify the item: echo, sign, or factor
    ST_LOAD,    // prime the divider with the remainder
    ST_DIV,     // one quotient bit per cycle
    ST_DECIDE,  // stop, take a factor, or try the next divisor
    ST_FINAL    // emit the remaining prime
  } tdf_state_t;

endpackage

FILE: sv/tdf_if.sv
// Valid/ready channel interfaces for the trial-division factorizer.
// Depend on nothing; width follows the value width parameter.
`timescale 1ns / 1ps

interface tdf_in_if #(parameter int VALUE_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tdf_out_if #(parameter int VALUE_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] factor;
  logic                         last;

  modport source (output valid, output factor, output last, input ready);
  modport sink   (input valid, input factor, input last, output ready);
endinterface

FILE: sv/trial_division_factorizer.sv
// Trial-division prime factorizer: one shared restoring divider under a sequencer.
// Each trial divisor takes a load, VALUE_BITS divide steps and a decide step,
// and operand.ready is high only between items.
// Results leave through an output register; synchronous active-high rst clears
// the sequencer, the remainder, the divisor and the output valid. Depends on tdf_pkg and tdf_if.
`timescale 1ns / 1ps

module trial_division_factorizer
  import tdf_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  tdf_in_if.sink    operand,
  tdf_out_if.source result
);

  localparam int CW = $clog2(VALUE_BITS);
  localparam logic [VALUE_BITS-1:0] ZERO = '0;
  localparam logic [VALUE_BITS-1:0] ONE  = VALUE_BITS'(1);
  localparam logic [VALUE_BITS-1:0] TWO  = VALUE_BITS'(2);

  tdf_state_t state, state_next;

  logic [VALUE_BITS-1:0] remainder;
  logic [VALUE_BITS-1:0] trial_divisor;
  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] part;
  logic [CW-1:0]         cnt;

  logic                  res_valid;
  logic [VALUE_BITS-1:0] res_factor;
  logic                  res_last;

  logic                  slot_free;
  logic                  is_small;
  logic                  is_neg;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;
  logic                  fits;
  logic [VALUE_BITS-1:0] part_step;
  logic                  stop;
  logic                  exact;

  logic                  emit;
  logic [VALUE_BITS-1:0] emit_factor;
  logic                  emit_last;

  // Classify the held item and form one divider step
  always_comb begin
    slot_free = !res_valid || result.ready;
    is_small  = (remainder[VALUE_BITS-1:1] == ZERO[VALUE_BITS-1:1]);
    is_neg    = remainder[VALUE_BITS-1];
    mag       = ~remainder + ONE;
    shifted   = {part, quo[VALUE_BITS-1]};
    diff      = shifted - {1'b0, trial_divisor};
    fits      = !diff[VALUE_BITS];
    part_step = fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
    stop      = (trial_divisor > quo);
    exact     = (part == ZERO);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (operand.valid) state_next = ST_START;
      end
      ST_START: begin
        if (is_small) begin
          if (slot_free) state_next = ST_IDLE;
        end else if (is_neg) begin
          if (slot_free) state_next = (mag == ONE) ? ST_IDLE : ST_LOAD;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == '0) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stop) state_next = ST_FINAL;
        else if (!exact || slot_free) state_next = ST_LOAD;
      end
      ST_FINAL: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and result selection
  always_comb begin
    operand.ready = (state == ST_IDLE);
    emit          = 1'b0;
    emit_factor   = remainder;
    emit_last     = 1'b1;
    case (state)
      ST_START: begin
        emit        = slot_free && (is_small || is_neg);
        emit_factor = is_small ? remainder : '1;
        emit_last   = is_small || (mag == ONE);
      end
      ST_DECIDE: begin
        emit        = slot_free && !stop && exact;
        emit_factor = trial_divisor;
        emit_last   = 1'b0;
      end
      ST_FINAL: begin
        emit        = slot_free;
        emit_factor = remainder;
        emit_last   = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Sequencer state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
    end
  end

  // Datapath: remainder, divisor and the shared divider
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder     <= '0;
      trial_divisor <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (operand.valid) remainder <= operand.value;
        end
        ST_START: begin
          trial_divisor <= TWO;
          if (is_neg && slot_free) remainder <= mag;
        end
        ST_LOAD: begin
          quo  <= remainder;
          part <= '0;
          cnt  <= CW'(VALUE_BITS - 1);
        end
        ST_DIV: begin
          quo  <= {quo[VALUE_BITS-2:0], fits};
          part <= part_step;
          cnt  <= cnt - 1'b1;
        end
        ST_DECIDE: begin
          if (!stop) begin
            if (!exact) trial_divisor <= trial_divisor + ONE;
            else if (slot_free) remainder <= quo;
          end
        end
        default: begin
          remainder <= remainder;
        end
      endcase
    end
    // Load the output register when the slot is free
    if (emit) begin
      res_factor <= emit_factor;
      res_last   <= emit_last;
    end
  end

  assign result.valid  = res_valid;
  assign result.factor = res_factor;
  assign result.last   = res_last;

endmodule

FILE: sv/tdf_checker.sv
// Port-level checker for the trial-division factorizer, bound to the top level.
// Depends on trial_division_factorizer_macros.svh.
`timescale 1ns / 1ps
`include "trial_division_factorizer_macros.svh"

module tdf_checker #(
  parameter int VALUE_BITS = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [VALUE_BITS-1:0] factor,
  input logic                         last
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] runs;
  logic       first;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count open runs; the item after a final one starts a new run
  always_ff @(posedge clk) begin
    if (rst) begin
      runs  <= 2'd0;
      first <= 1'b1;
    end else begin
      if (in_acc && !(out_acc && last)) runs <= runs + 2'd1;
      else if (!in_acc && out_acc && last) runs <= runs - 2'd1;
      if (out_acc) first <= last;
    end
  end

  // A stalled item holds
  `TDF_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(factor) && $stable(last))
  // A new item may only arrive while at most the final item of the previous run waits
  `TDF_ASSERT_ALWAYS(a_one_run, !in_acc || runs == 2'd0 || (runs == 2'd1 && out_valid && last))
  // Results appear only inside a run
  `TDF_ASSERT_ALWAYS(a_in_run, !out_valid || runs != 2'd0)
  // The sign marker is only ever the first item of a run
  `TDF_ASSERT_ALWAYS(a_sign_first, !(out_acc && factor == -1) || first)
  // Every non-final factor other than the sign is at least two
  `TDF_ASSERT_ALWAYS(a_prime_min, !(out_acc && !last && factor != -1) || factor >= 2)

endmodule

bind trial_division_factorizer tdf_checker #(.VALUE_BITS(VALUE_BITS)) u_tdf_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (operand.valid),
  .in_ready (operand.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .factor   (result.factor),
  .last     (result.last)
);

FILE: bench/tb.sv
// Testbench for trial_division_factorizer: drives signed integers, predicts each prime run.
// Depends on the tdf_in_if / tdf_out_if interfaces and the trial_division_factorizer top.
`timescale 1ns / 1ps

module tb;

  localparam int VALUE_BITS = 32;
  // Slowest item used here is 997 squared, with no handshake until its first factor
  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 3 * (VALUE_BITS + 2);

  typedef struct {
    logic signed [VALUE_BITS-1:0] factor;
    logic                         last;
  } factor_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tdf_in_if  #(.VALUE_BITS(VALUE_BITS)) operand_ch ();
  tdf_out_if #(.VALUE_BITS(VALUE_BITS)) result_ch ();

  trial_division_factorizer #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_ch),
    .result  (result_ch)
  );

  factor_item_t pending_factors[$];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  sender_idle_pct = 0;
  int unsigned  receiver_stall_pct = 0;
  int unsigned  small_primes [15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue one expected factor
  function automatic void append_factor(input logic signed [VALUE_BITS-1:0] factor,
                                        input logic last);
    factor_item_t item;
    item.factor = factor;
    item.last   = last;
    pending_factors.push_back(item);
  endfunction

  // Work out the factor run of one value by trial division
  function automatic void predict_factorization(input logic signed [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] magnitude;
    longint unsigned       rest;
    longint unsigned       divisor;
    magnitude = value;
    if (magnitude == 0 || magnitude == 1) begin
      append_factor(value, 1'b1);
      return;
    end
    // Sign first; the most negative value wraps to 2^(VALUE_BITS-1) as unsigned
    if (value < 0) begin
      magnitude = -value;
      append_factor(-1, magnitude == 1);
    end
    rest    = magnitude;
    divisor = 2;
    while (rest > 1 && divisor <= rest / divisor) begin
      if (rest % divisor == 0) begin
        rest = rest / divisor;
        append_factor(divisor[VALUE_BITS-1:0], rest == 1);
      end else begin
        divisor++;
      end
    end
    // Whatever is left above one is the largest prime
    if (rest > 1)
      append_factor(rest[VALUE_BITS-1:0], 1'b1);
  endfunction

  // A modest cofactor times small primes, or a plain value up to 20000, so divisors stay small
  function automatic logic signed [VALUE_BITS-1:0] random_operand();
    longint unsigned              mag;
    longint unsigned              prime;
    int unsigned                  mults;
    logic signed [VALUE_BITS-1:0] operand;
    if ($urandom_range(4, 0) == 0) begin
      mag = $urandom_range(20000, 0);
    end else begin
      mag   = $urandom_range(5000, 2);
      mults = $urandom_range(24, 0);
      repeat (mults) begin
        prime = small_primes[$urandom_range(14, 0)];
        if (mag * prime <= 64'h7fff_ffff)
          mag = mag * prime;
      end
    end
    operand = mag[VALUE_BITS-1:0];
    if ($urandom_range(2, 0) == 0)
      operand = -operand;
    return operand;
  endfunction

  // Offer one item after a random idle gap, hold it until taken
  task automatic send_value(input logic signed [VALUE_BITS-1:0] value);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99, 0) < sender_idle_pct)
      gap++;
    if (gap != 0) begin
      operand_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operand_ch.valid <= 1'b1;
    operand_ch.value <= value;
    do @(posedge clk); while (!operand_ch.ready);
    predict_factorization(value);
  endtask

  // Receiver: stall at random, check every item taken against the oldest expectation
  always @(posedge clk) begin
    factor_item_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_factors.size() == 0) begin
          $display("%0t: unexpected factor %0d last %0b", $time,
                   result_ch.factor, result_ch.last);
          mismatch_count++;
        end else begin
          want = pending_factors.pop_front();
          if (result_ch.factor !== want.factor) begin
            $display("%0t: factor expected %0d, got %0d", $time, want.factor,
                     result_ch.factor);
            mismatch_count++;
          end
          if (result_ch.last !== want.last) begin
            $display("%0t: last expected %0b, got %0b", $time, want.last, result_ch.last);
            mismatch_count++;
          end
        end
      end
      result_ch.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
    end
  end

  // Watchdog: abort after too long without any handshake
  always @(posedge clk) begin
    if ((operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("[trial_division_factorizer] ERROR");
      $finish;
    end
  end

  task automatic test_trivial_values();
    send_value(0);
    send_value(1);
    send_value(-1);
  endtask

  task automatic test_small_signed_values();
    send_value(2);
    send_value(3);
    send_value(4);
    send_value(-2);
    send_value(-3);
    send_value(-12);
  endtask

  // Field extremes with cheap factorizations; the most negative value gives the longest run
  task automatic test_extreme_values();
    send_value(32'sh8000_0000);
    send_value(32'sh4000_0000);
    send_value(-32'sh4000_0000);
    send_value(2147483646);
    send_value(-2147483646);
    send_value(1162261467);
  endtask

  // Primes and 997 squared push the divisor far past the small primes; 223092870 does not
  task automatic test_primes_and_squares();
    send_value(9973);
    send_value(-9973);
    send_value(994009);
    send_value(223092870);
  endtask

  task automatic test_random_factorizations(input int unsigned count);
    repeat (count)
      send_value(random_operand());
  endtask

  initial begin
    operand_ch.valid <= 1'b0;
    operand_ch.value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Sender seldom idle, receiver mostly stalled
    sender_idle_pct    = 8;
    receiver_stall_pct = 82;
    test_trivial_values();
    test_small_signed_values();
    test_extreme_values();
    test_primes_and_squares();
    test_random_factorizations(27);

    // Swap the roles
    sender_idle_pct    = 82;
    receiver_stall_pct = 8;
    test_random_factorizations(27);

    // Full throughput on both sides
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    test_random_factorizations(27);

    // Drain outstanding factors, then allow stray items to show up
    operand_ch.valid <= 1'b0;
    while (pending_factors.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("[trial_division_factorizer] OK");
    else
      $display("[trial_division_factorizer] ERROR");
    $finish;
  end

endmodule

FILE: trial_division_factorizer.f
+incdir+sv
sv/tdf_pkg.sv
sv/tdf_if.sv
sv/trial_division_factorizer.sv
sv/tdf_checker.sv
bench/tb.sv
